// ===== rtl/core/csts_pkg.sv =====
package csts_pkg;

   // field widths
   localparam int LINE_BITS    = 16;
   localparam int OFFSET_BITS  = 24;
   localparam int LENGTH_BITS  = 8;
   localparam int TYPE_BITS    = 6;
   localparam int ERR_BITS     = 2;
   localparam int CHAR_BITS    = 8;
   localparam int PREFIX_BYTES = 6;

   // result queue geometry
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   typedef logic [TYPE_BITS-1:0] token_code_type;
   typedef logic [ERR_BITS-1:0]  err_code_type;

   // token classes
   localparam token_code_type TOK_LPAREN    = 6'd0;
   localparam token_code_type TOK_RPAREN    = 6'd1;
   localparam token_code_type TOK_LBRACE    = 6'd2;
   localparam token_code_type TOK_RBRACE    = 6'd3;
   localparam token_code_type TOK_SEMI      = 6'd4;
   localparam token_code_type TOK_TILDE     = 6'd5;
   localparam token_code_type TOK_PLUS      = 6'd6;
   localparam token_code_type TOK_INC       = 6'd7;
   localparam token_code_type TOK_MINUS     = 6'd8;
   localparam token_code_type TOK_DEC       = 6'd9;
   localparam token_code_type TOK_STAR      = 6'd10;
   localparam token_code_type TOK_SLASH     = 6'd11;
   localparam token_code_type TOK_PERCENT   = 6'd12;
   localparam token_code_type TOK_LT        = 6'd13;
   localparam token_code_type TOK_LE        = 6'd14;
   localparam token_code_type TOK_SHL       = 6'd15;
   localparam token_code_type TOK_GT        = 6'd16;
   localparam token_code_type TOK_GE        = 6'd17;
   localparam token_code_type TOK_SHR       = 6'd18;
   localparam token_code_type TOK_EQ        = 6'd19;
   localparam token_code_type TOK_AMP       = 6'd20;
   localparam token_code_type TOK_LAND      = 6'd21;
   localparam token_code_type TOK_PIPE      = 6'd22;
   localparam token_code_type TOK_LOR       = 6'd23;
   localparam token_code_type TOK_CARET     = 6'd24;
   localparam token_code_type TOK_BANG      = 6'd25;
   localparam token_code_type TOK_NE        = 6'd26;
   localparam token_code_type TOK_NUMBER    = 6'd27;
   localparam token_code_type TOK_IDENT     = 6'd28;
   localparam token_code_type TOK_KW_INT    = 6'd29;
   localparam token_code_type TOK_KW_RETURN = 6'd30;
   localparam token_code_type TOK_KW_VOID   = 6'd31;
   localparam token_code_type TOK_END       = 6'd32;
   localparam token_code_type TOK_NONE      = 6'd63;
   // error beats carry a class with no meaning
   localparam token_code_type TOK_ERR_FILL  = TOK_LPAREN;

   // error codes
   localparam err_code_type ERR_NONE       = 2'd0;
   localparam err_code_type ERR_UNEXPECTED = 2'd1;
   localparam err_code_type ERR_LONE_EQ    = 2'd2;

   typedef struct packed {
      token_code_type          token_type;
      err_code_type            error_code;
      logic [LINE_BITS-1:0]    start_line;
      logic [LINE_BITS-1:0]    start_column;
      logic [OFFSET_BITS-1:0]  start_offset;
      logic [LENGTH_BITS-1:0]  token_length;
      logic                    last_of_run;
   } result_type;

   // up to two results produced by one scanned byte
   typedef struct packed {
      logic [1:0]  count;
      result_type  first;
      result_type  second;
   } scan_push_type;

endpackage

// ===== rtl/core/csts_scan.sv =====
module csts_scan
   import csts_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic                  in_kind,
   input  logic [CHAR_BITS-1:0]  in_byte,
   input  logic                  room,
   output logic                  push_valid,
   output scan_push_type         push
);

   localparam logic [2:0] MODE_IDLE   = 3'd0;
   localparam logic [2:0] MODE_NUMBER = 3'd1;
   localparam logic [2:0] MODE_IDENT  = 3'd2;
   localparam logic [2:0] MODE_OPER   = 3'd3;
   localparam logic [2:0] MODE_ERROR  = 3'd4;

   localparam logic [CHAR_BITS-1:0] CH_TAB = 8'h09;
   localparam logic [CHAR_BITS-1:0] CH_NL  = 8'h0A;
   localparam logic [CHAR_BITS-1:0] CH_CR  = 8'h0D;

   localparam logic [8*PREFIX_BYTES-1:0] KW_INT    = 48'h0000_0074_6E69;
   localparam logic [8*PREFIX_BYTES-1:0] KW_RETURN = 48'h6E72_7574_6572;
   localparam logic [8*PREFIX_BYTES-1:0] KW_VOID   = 48'h0000_6469_6F76;

   typedef struct packed {
      logic [2:0]                   mode;
      logic [CHAR_BITS-1:0]         pend;
      logic [8*PREFIX_BYTES-1:0]    prefix;
      logic [LENGTH_BITS-1:0]       run_len;
      logic [LINE_BITS-1:0]         run_line;
      logic [LINE_BITS-1:0]         run_col;
      logic [OFFSET_BITS-1:0]       run_off;
      logic [LINE_BITS-1:0]         cur_line;
      logic [LINE_BITS-1:0]         cur_col;
      logic [OFFSET_BITS-1:0]       cur_off;
   } scan_state_type;

   localparam scan_state_type ST_RESET = '{
      mode:     MODE_IDLE,
      pend:     '0,
      prefix:   '0,
      run_len:  '0,
      run_line: LINE_BITS'(1),
      run_col:  LINE_BITS'(1),
      run_off:  '0,
      cur_line: LINE_BITS'(1),
      cur_col:  LINE_BITS'(1),
      cur_off:  '0
   };

   // character classes
   function automatic logic is_digit(input logic [CHAR_BITS-1:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_letter(input logic [CHAR_BITS-1:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_space(input logic [CHAR_BITS-1:0] c);
      return c == " " || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic is_word(input logic [CHAR_BITS-1:0] c);
      return is_letter(c) || is_digit(c) || c == "_";
   endfunction

   function automatic logic starts_pair(input logic [CHAR_BITS-1:0] c);
      return c == "+" || c == "-" || c == "<" || c == ">" || c == "="
         || c == "&" || c == "|" || c == "!";
   endfunction

   function automatic token_code_type single_type(input logic [CHAR_BITS-1:0] c);
      token_code_type t;
      case (c)
         "(": t = TOK_LPAREN;
         ")": t = TOK_RPAREN;
         "{": t = TOK_LBRACE;
         "}": t = TOK_RBRACE;
         ";": t = TOK_SEMI;
         "~": t = TOK_TILDE;
         "+": t = TOK_PLUS;
         "-": t = TOK_MINUS;
         "*": t = TOK_STAR;
         "/": t = TOK_SLASH;
         "%": t = TOK_PERCENT;
         "<": t = TOK_LT;
         ">": t = TOK_GT;
         "&": t = TOK_AMP;
         "|": t = TOK_PIPE;
         "^": t = TOK_CARET;
         "!": t = TOK_BANG;
         default: t = TOK_NONE;
      endcase
      return t;
   endfunction

   function automatic token_code_type pair_type(input logic [CHAR_BITS-1:0] p,
                                                input logic [CHAR_BITS-1:0] c);
      token_code_type t;
      t = TOK_NONE;
      if (p == "+" && c == "+") t = TOK_INC;
      if (p == "-" && c == "-") t = TOK_DEC;
      if (p == "<" && c == "=") t = TOK_LE;
      if (p == "<" && c == "<") t = TOK_SHL;
      if (p == ">" && c == "=") t = TOK_GE;
      if (p == ">" && c == ">") t = TOK_SHR;
      if (p == "=" && c == "=") t = TOK_EQ;
      if (p == "&" && c == "&") t = TOK_LAND;
      if (p == "|" && c == "|") t = TOK_LOR;
      if (p == "!" && c == "=") t = TOK_NE;
      return t;
   endfunction

   function automatic result_type make_res(input token_code_type t,
                                           input err_code_type e,
                                           input logic [LINE_BITS-1:0] line,
                                           input logic [LINE_BITS-1:0] col,
                                           input logic [OFFSET_BITS-1:0] off,
                                           input logic [LENGTH_BITS-1:0] len);
      result_type r;
      r.token_type   = t;
      r.error_code   = e;
      r.start_line   = line;
      r.start_column = col;
      r.start_offset = off;
      r.token_length = len;
      r.last_of_run  = 1'b0;
      return r;
   endfunction

   // step line, column and offset past one byte
   function automatic scan_state_type advance(input scan_state_type s,
                                              input logic [CHAR_BITS-1:0] c);
      scan_state_type r;
      r = s;
      if (c == CH_NL) begin
         r.cur_line = (&s.cur_line) ? s.cur_line : s.cur_line + LINE_BITS'(1);
         r.cur_col  = LINE_BITS'(1);
      end else begin
         r.cur_col = (&s.cur_col) ? s.cur_col : s.cur_col + LINE_BITS'(1);
      end
      r.cur_off = s.cur_off + OFFSET_BITS'(1);
      return r;
   endfunction

   // append a byte to the running token
   function automatic scan_state_type add_char(input scan_state_type s,
                                               input logic [CHAR_BITS-1:0] c);
      scan_state_type r;
      r = s;
      for (int i = 0; i < PREFIX_BYTES; i++) begin
         if (s.run_len == LENGTH_BITS'(i)) r.prefix[CHAR_BITS*i +: CHAR_BITS] = c;
      end
      r.run_len = (&s.run_len) ? s.run_len : s.run_len + LENGTH_BITS'(1);
      return advance(r, c);
   endfunction

   // open a token at the current position
   function automatic scan_state_type begin_run(input scan_state_type s,
                                                input logic [2:0] m);
      scan_state_type r;
      r = s;
      r.run_line = s.cur_line;
      r.run_col  = s.cur_col;
      r.run_off  = s.cur_off;
      r.run_len  = '0;
      r.prefix   = '0;
      r.mode     = m;
      return r;
   endfunction

   scan_state_type        st_ff, st_in;
   logic                  in_vld_ff, in_vld_in;
   logic                  kind_ff;
   logic [CHAR_BITS-1:0]  byte_ff;
   logic                  fire;
   logic                  fresh;
   logic [1:0]            cnt;
   result_type            res [2];
   result_type            flush_res;
   result_type            close_res;
   token_code_type        ident_type;
   token_code_type        pair_t;
   token_code_type        fresh_single;

   // input register handshake
   assign fire      = in_vld_ff & room;
   assign in_ready  = ~in_vld_ff | room;
   assign in_vld_in = (in_valid & in_ready) | (in_vld_ff & ~room);

   // identifier or keyword
   always_comb begin
      ident_type = TOK_IDENT;
      if (st_ff.run_len == LENGTH_BITS'(3) && st_ff.prefix == KW_INT)
         ident_type = TOK_KW_INT;
      else if (st_ff.run_len == LENGTH_BITS'(6) && st_ff.prefix == KW_RETURN)
         ident_type = TOK_KW_RETURN;
      else if (st_ff.run_len == LENGTH_BITS'(4) && st_ff.prefix == KW_VOID)
         ident_type = TOK_KW_VOID;
   end

   // results for a run or a pending single operator, closed by another byte or an end beat
   assign flush_res = make_res((st_ff.mode == MODE_IDENT) ? ident_type : TOK_NUMBER,
                               ERR_NONE, st_ff.run_line, st_ff.run_col, st_ff.run_off,
                               st_ff.run_len);
   assign close_res = (st_ff.pend == "=")
      ? make_res(TOK_ERR_FILL, ERR_LONE_EQ, st_ff.run_line, st_ff.run_col,
                 st_ff.run_off, LENGTH_BITS'(1))
      : make_res(single_type(st_ff.pend), ERR_NONE, st_ff.run_line, st_ff.run_col,
                 st_ff.run_off, LENGTH_BITS'(1));

   assign pair_t       = pair_type(st_ff.pend, byte_ff);
   assign fresh_single = single_type(byte_ff);

   // scan one byte: mode update and up to two results
   always_comb begin
      st_in  = st_ff;
      res[0] = '0;
      res[1] = '0;
      cnt    = 2'd0;
      fresh  = 1'b0;
      if (kind_ff) begin
         if (st_ff.mode == MODE_NUMBER || st_ff.mode == MODE_IDENT) begin
            res[0] = flush_res;
            cnt    = 2'd1;
         end else if (st_ff.mode == MODE_OPER) begin
            res[0] = close_res;
            cnt    = 2'd1;
         end
         res[cnt[0]] = make_res(TOK_END, ERR_NONE, st_ff.cur_line, st_ff.cur_col,
                                st_ff.cur_off, '0);
         cnt   = cnt + 2'd1;
         st_in = ST_RESET;
      end else begin
         case (st_ff.mode)
            MODE_IDLE: begin
               fresh = 1'b1;
            end
            MODE_NUMBER: begin
               if (is_digit(byte_ff)) begin
                  st_in = add_char(st_ff, byte_ff);
               end else begin
                  res[0]     = flush_res;
                  cnt        = 2'd1;
                  st_in.mode = MODE_IDLE;
                  fresh      = 1'b1;
               end
            end
            MODE_IDENT: begin
               if (is_word(byte_ff)) begin
                  st_in = add_char(st_ff, byte_ff);
               end else begin
                  res[0]     = flush_res;
                  cnt        = 2'd1;
                  st_in.mode = MODE_IDLE;
                  fresh      = 1'b1;
               end
            end
            MODE_OPER: begin
               if (pair_t != TOK_NONE) begin
                  st_in      = add_char(st_ff, byte_ff);
                  res[0]     = make_res(pair_t, ERR_NONE, st_ff.run_line, st_ff.run_col,
                                        st_ff.run_off, st_in.run_len);
                  cnt        = 2'd1;
                  st_in.pend = '0;
                  st_in.mode = MODE_IDLE;
               end else begin
                  res[0]     = close_res;
                  cnt        = 2'd1;
                  st_in.pend = '0;
                  if (st_ff.pend == "=") begin
                     st_in.mode = MODE_ERROR;
                  end else begin
                     st_in.mode = MODE_IDLE;
                     fresh      = 1'b1;
                  end
               end
            end
            default: begin
               st_in.mode = MODE_ERROR;
            end
         endcase

         // byte scanned afresh; position is untouched by a flush or close
         if (fresh) begin
            if (is_space(byte_ff)) begin
               st_in = advance(st_in, byte_ff);
            end else if (is_digit(byte_ff)) begin
               st_in = add_char(begin_run(st_in, MODE_NUMBER), byte_ff);
            end else if (is_letter(byte_ff) || byte_ff == "_") begin
               st_in = add_char(begin_run(st_in, MODE_IDENT), byte_ff);
            end else if (starts_pair(byte_ff)) begin
               st_in      = add_char(begin_run(st_in, MODE_OPER), byte_ff);
               st_in.pend = byte_ff;
            end else if (fresh_single == TOK_NONE) begin
               res[cnt[0]] = make_res(TOK_ERR_FILL, ERR_UNEXPECTED, st_ff.cur_line,
                                      st_ff.cur_col, st_ff.cur_off, LENGTH_BITS'(1));
               cnt         = cnt + 2'd1;
               st_in.mode  = MODE_ERROR;
            end else begin
               res[cnt[0]] = make_res(fresh_single, ERR_NONE, st_ff.cur_line,
                                      st_ff.cur_col, st_ff.cur_off, LENGTH_BITS'(1));
               cnt         = cnt + 2'd1;
               st_in       = advance(st_in, byte_ff);
            end
         end
      end
   end

   // hand results to the queue, last one flagged
   always_comb begin
      push_valid              = fire;
      push.count              = cnt;
      push.first              = res[0];
      push.second             = res[1];
      push.first.last_of_run  = (cnt == 2'd1);
      push.second.last_of_run = (cnt == 2'd2);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         st_ff     <= ST_RESET;
      end else begin
         in_vld_ff <= in_vld_in;
         if (fire) st_ff <= st_in;
      end
   end

   // input beat payload
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         kind_ff <= in_kind;
         byte_ff <= in_byte;
      end
   end

endmodule

// ===== rtl/core/csts_queue.sv =====
module csts_queue
   import csts_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   input  scan_push_type  push,
   output logic           room,
   output logic           out_valid,
   input  logic           out_ready,
   output result_type     out_data
);

   result_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  head_ff, head_in;
   logic [QPTR_BITS-1:0]  tail_ff, tail_in;
   logic [QPTR_BITS:0]    count_ff, count_in;
   logic [1:0]            push_n;
   logic                  pop;

   // room for a full pair of results
   assign room      = count_ff <= (QPTR_BITS+1)'(QUEUE_DEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_data  = entry_ff[head_ff];
   assign pop       = out_valid & out_ready;
   assign push_n    = push_valid ? push.count : 2'd0;

   // pointer and fill update
   assign head_in  = head_ff + QPTR_BITS'(pop);
   assign tail_in  = tail_ff + QPTR_BITS'(push_n);
   assign count_in = count_ff + (QPTR_BITS+1)'(push_n) - (QPTR_BITS+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) entry_ff[tail_ff] <= push.first;
      if (push_n == 2'd2) entry_ff[tail_ff + QPTR_BITS'(1)] <= push.second;
   end

endmodule

// ===== rtl/core/c_subset_token_scanner.sv =====
// a byte waits in the input register until the result queue has room
// for a pair of results; throughput: one byte per cycle while it has
// room; a byte yielding two results is absorbed by the four-entry queue
// reset: synchronous, active high; clears the scan mode, position counters,
// input register and result queue; bytes are taken from the next cycle on
module c_subset_token_scanner
   import csts_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_kind,
   input  logic [CHAR_BITS-1:0]    req_text_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [TYPE_BITS-1:0]    rsp_token_type,
   output logic [ERR_BITS-1:0]     rsp_error_code,
   output logic [LINE_BITS-1:0]    rsp_start_line,
   output logic [LINE_BITS-1:0]    rsp_start_column,
   output logic [OFFSET_BITS-1:0]  rsp_start_offset,
   output logic [LENGTH_BITS-1:0]  rsp_token_length,
   output logic                    rsp_last_of_run
);

   logic           room;
   logic           push_valid;
   scan_push_type  push;
   result_type     rsp_data;

   // byte scanner
   csts_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_kind    (req_kind),
      .in_byte    (req_text_byte),
      .room       (room),
      .push_valid (push_valid),
      .push       (push)
   );

   // result queue
   csts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push       (push),
      .room       (room),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (rsp_data)
   );

   // result beat fields
   assign rsp_token_type   = rsp_data.token_type;
   assign rsp_error_code   = rsp_data.error_code;
   assign rsp_start_line   = rsp_data.start_line;
   assign rsp_start_column = rsp_data.start_column;
   assign rsp_start_offset = rsp_data.start_offset;
   assign rsp_token_length = rsp_data.token_length;
   assign rsp_last_of_run  = rsp_data.last_of_run;

endmodule

// ===== rtl/core/csts_check.sv =====
module csts_check
   import csts_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic [TYPE_BITS-1:0]    rsp_token_type,
   input  logic [ERR_BITS-1:0]     rsp_error_code,
   input  logic [LINE_BITS-1:0]    rsp_start_line,
   input  logic [LINE_BITS-1:0]    rsp_start_column,
   input  logic [LENGTH_BITS-1:0]  rsp_token_length,
   input  logic                    rsp_last_of_run
);

   // a stalled result beat stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat withdrawn while stalled");

   // nothing offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

   // end marker closes its run and is empty
   a_end_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_type == TOK_END |->
         rsp_last_of_run && rsp_error_code == ERR_NONE && rsp_token_length == '0)
      else $error("malformed end marker");

   // error beats are one byte long with positions from one
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != ERR_NONE |->
         rsp_token_length == LENGTH_BITS'(1) && rsp_token_type == TOK_ERR_FILL
         && rsp_start_line != '0 && rsp_start_column != '0)
      else $error("malformed error beat");

endmodule

bind c_subset_token_scanner csts_check u_csts_check (.*);

// ===== tb/tb_c_subset_token_scanner.sv =====
`timescale 1ns / 100ps

module tb_c_subset_token_scanner;
   import csts_pkg::*;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TAIL_CYCLES    = 16;
   localparam int LONG_RUN       = 260;
   localparam int REPORT_LINES   = 100;

   // whitespace bytes
   localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'd9;
   localparam logic [CHAR_BITS-1:0] CH_LF    = 8'd10;
   localparam logic [CHAR_BITS-1:0] CH_VT    = 8'd11;
   localparam logic [CHAR_BITS-1:0] CH_FF    = 8'd12;
   localparam logic [CHAR_BITS-1:0] CH_CR    = 8'd13;
   localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'd32;

   // keywords as held in the word head, first character in the lowest byte
   localparam logic [8*PREFIX_BYTES-1:0] WORD_INT    = {24'd0, "t", "n", "i"};
   localparam logic [8*PREFIX_BYTES-1:0] WORD_RETURN = {"n", "r", "u", "t", "e", "r"};
   localparam logic [8*PREFIX_BYTES-1:0] WORD_VOID   = {16'd0, "d", "i", "o", "v"};

   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_NUMBER,
      SCAN_IDENT,
      SCAN_OPER,
      SCAN_ERROR
   } scan_mode_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_kind = KIND_BYTE;
   logic [CHAR_BITS-1:0]    req_text_byte = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [TYPE_BITS-1:0]    rsp_token_type;
   logic [ERR_BITS-1:0]     rsp_error_code;
   logic [LINE_BITS-1:0]    rsp_start_line;
   logic [LINE_BITS-1:0]    rsp_start_column;
   logic [OFFSET_BITS-1:0]  rsp_start_offset;
   logic [LENGTH_BITS-1:0]  rsp_token_length;
   logic                    rsp_last_of_run;

   // scanner state as predicted
   scan_mode_type              mode;
   logic [CHAR_BITS-1:0]       pend_op;
   logic [8*PREFIX_BYTES-1:0]  word_head;
   logic [LENGTH_BITS-1:0]     run_len;
   logic [LINE_BITS-1:0]       run_line;
   logic [LINE_BITS-1:0]       run_col;
   logic [OFFSET_BITS-1:0]     run_off;
   logic [LINE_BITS-1:0]       cur_line;
   logic [LINE_BITS-1:0]       cur_col;
   logic [OFFSET_BITS-1:0]     cur_off;

   result_type   beat_tokens[$];
   result_type   tokens_due[$];
   result_type   want;

   int unsigned  sender_gap_pct = 0;
   int unsigned  receiver_stall_pct = 0;
   int unsigned  beats_sent = 0;
   int unsigned  results_checked = 0;
   int unsigned  mismatches = 0;
   int unsigned  quiet_cycles = 0;

   c_subset_token_scanner dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_text_byte    (req_text_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_type   (rsp_token_type),
      .rsp_error_code   (rsp_error_code),
      .rsp_start_line   (rsp_start_line),
      .rsp_start_column (rsp_start_column),
      .rsp_start_offset (rsp_start_offset),
      .rsp_token_length (rsp_token_length),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // character classes
   function automatic bit is_digit(input logic [CHAR_BITS-1:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_letter(input logic [CHAR_BITS-1:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit is_space(input logic [CHAR_BITS-1:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic bit starts_pair(input logic [CHAR_BITS-1:0] c);
      return c == "+" || c == "-" || c == "<" || c == ">" || c == "="
         || c == "&" || c == "|" || c == "!";
   endfunction

   function automatic token_code_type single_code(input logic [CHAR_BITS-1:0] c);
      case (c)
         "(": return TOK_LPAREN;
         ")": return TOK_RPAREN;
         "{": return TOK_LBRACE;
         "}": return TOK_RBRACE;
         ";": return TOK_SEMI;
         "~": return TOK_TILDE;
         "+": return TOK_PLUS;
         "-": return TOK_MINUS;
         "*": return TOK_STAR;
         "/": return TOK_SLASH;
         "%": return TOK_PERCENT;
         "<": return TOK_LT;
         ">": return TOK_GT;
         "&": return TOK_AMP;
         "|": return TOK_PIPE;
         "^": return TOK_CARET;
         "!": return TOK_BANG;
         default: return TOK_NONE;
      endcase
   endfunction

   function automatic token_code_type pair_code(input logic [CHAR_BITS-1:0] p,
                                                input logic [CHAR_BITS-1:0] c);
      if (p == "+" && c == "+") return TOK_INC;
      if (p == "-" && c == "-") return TOK_DEC;
      if (p == "<" && c == "=") return TOK_LE;
      if (p == "<" && c == "<") return TOK_SHL;
      if (p == ">" && c == "=") return TOK_GE;
      if (p == ">" && c == ">") return TOK_SHR;
      if (p == "=" && c == "=") return TOK_EQ;
      if (p == "&" && c == "&") return TOK_LAND;
      if (p == "|" && c == "|") return TOK_LOR;
      if (p == "!" && c == "=") return TOK_NE;
      return TOK_NONE;
   endfunction

   function automatic logic [LINE_BITS-1:0] sat_step(input logic [LINE_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic void reset_scan();
      mode      = SCAN_IDLE;
      pend_op   = '0;
      word_head = '0;
      run_len   = '0;
      run_line  = LINE_BITS'(1);
      run_col   = LINE_BITS'(1);
      run_off   = '0;
      cur_line  = LINE_BITS'(1);
      cur_col   = LINE_BITS'(1);
      cur_off   = '0;
   endfunction

   function automatic void push_token(input token_code_type tt, input err_code_type ec,
                                      input logic [LINE_BITS-1:0] ln,
                                      input logic [LINE_BITS-1:0] col,
                                      input logic [OFFSET_BITS-1:0] off,
                                      input logic [LENGTH_BITS-1:0] len);
      result_type r;
      r.token_type   = tt;
      r.error_code   = ec;
      r.start_line   = ln;
      r.start_column = col;
      r.start_offset = off;
      r.token_length = len;
      r.last_of_run  = 1'b0;
      beat_tokens.push_back(r);
   endfunction

   function automatic void advance_position(input logic [CHAR_BITS-1:0] c);
      if (c == CH_LF) begin
         cur_line = sat_step(cur_line);
         cur_col  = LINE_BITS'(1);
      end else begin
         cur_col = sat_step(cur_col);
      end
      cur_off = cur_off + 1'b1;
   endfunction

   function automatic void start_run();
      run_line  = cur_line;
      run_col   = cur_col;
      run_off   = cur_off;
      run_len   = '0;
      word_head = '0;
   endfunction

   // only the first few characters are kept for keyword matching
   function automatic void extend_run(input logic [CHAR_BITS-1:0] c);
      if (run_len < PREFIX_BYTES) begin
         word_head[8*run_len +: 8] = c;
      end
      if (!(&run_len)) begin
         run_len = run_len + 1'b1;
      end
      advance_position(c);
   endfunction

   // number or identifier, keywords only on a whole-word match
   function automatic void close_run();
      token_code_type tt;
      tt = TOK_NUMBER;
      if (mode == SCAN_IDENT) begin
         tt = TOK_IDENT;
         if (run_len == 3 && word_head == WORD_INT) begin
            tt = TOK_KW_INT;
         end else if (run_len == 6 && word_head == WORD_RETURN) begin
            tt = TOK_KW_RETURN;
         end else if (run_len == 4 && word_head == WORD_VOID) begin
            tt = TOK_KW_VOID;
         end
      end
      push_token(tt, ERR_NONE, run_line, run_col, run_off, run_len);
      mode = SCAN_IDLE;
   endfunction

   // pending operator that found no partner
   function automatic void close_single_op();
      if (pend_op == "=") begin
         push_token(TOK_ERR_FILL, ERR_LONE_EQ, run_line, run_col, run_off,
                    LENGTH_BITS'(1));
         mode = SCAN_ERROR;
      end else begin
         push_token(single_code(pend_op), ERR_NONE, run_line, run_col, run_off,
                    LENGTH_BITS'(1));
         mode = SCAN_IDLE;
      end
      pend_op = '0;
   endfunction

   function automatic void scan_fresh(input logic [CHAR_BITS-1:0] c);
      token_code_type tt;
      if (is_space(c)) begin
         advance_position(c);
      end else if (is_digit(c)) begin
         start_run();
         mode = SCAN_NUMBER;
         extend_run(c);
      end else if (is_letter(c) || c == "_") begin
         start_run();
         mode = SCAN_IDENT;
         extend_run(c);
      end else if (starts_pair(c)) begin
         start_run();
         mode    = SCAN_OPER;
         pend_op = c;
         extend_run(c);
      end else begin
         tt = single_code(c);
         if (tt == TOK_NONE) begin
            push_token(TOK_ERR_FILL, ERR_UNEXPECTED, cur_line, cur_col, cur_off,
                       LENGTH_BITS'(1));
            mode = SCAN_ERROR;
         end else begin
            push_token(tt, ERR_NONE, cur_line, cur_col, cur_off, LENGTH_BITS'(1));
            advance_position(c);
         end
      end
   endfunction

   // tokens caused by one accepted beat, queued in order
   function automatic void scan_beat(input logic kind, input logic [CHAR_BITS-1:0] c);
      token_code_type tt;
      result_type     r;
      beat_tokens.delete();
      if (kind == KIND_END) begin
         if (mode == SCAN_NUMBER || mode == SCAN_IDENT) begin
            close_run();
         end else if (mode == SCAN_OPER) begin
            close_single_op();
         end
         push_token(TOK_END, ERR_NONE, cur_line, cur_col, cur_off, '0);
         reset_scan();
      end else begin
         case (mode)
            SCAN_IDLE: begin
               scan_fresh(c);
            end
            SCAN_NUMBER: begin
               if (is_digit(c)) begin
                  extend_run(c);
               end else begin
                  close_run();
                  scan_fresh(c);
               end
            end
            SCAN_IDENT: begin
               if (is_letter(c) || is_digit(c) || c == "_") begin
                  extend_run(c);
               end else begin
                  close_run();
                  scan_fresh(c);
               end
            end
            SCAN_OPER: begin
               tt = pair_code(pend_op, c);
               if (tt != TOK_NONE) begin
                  extend_run(c);
                  push_token(tt, ERR_NONE, run_line, run_col, run_off, run_len);
                  pend_op = '0;
                  mode    = SCAN_IDLE;
               end else begin
                  close_single_op();
                  if (mode == SCAN_IDLE) begin
                     scan_fresh(c);
                  end
               end
            end
            default: begin
               // discarding until end of text
               mode = SCAN_ERROR;
            end
         endcase
      end
      if (beat_tokens.size() > 0) begin
         r = beat_tokens[beat_tokens.size()-1];
         r.last_of_run = 1'b1;
         beat_tokens[beat_tokens.size()-1] = r;
      end
      foreach (beat_tokens[i]) begin
         tokens_due.push_back(beat_tokens[i]);
      end
   endfunction

   task report_mismatch(input string what, input longint unsigned got,
                        input longint unsigned wanted);
      // keep the log short on a badly broken block
      if (mismatches < REPORT_LINES) begin
         $display("mismatch on token %0d: %s is %0d, expected %0d",
                  results_checked, what, got, wanted);
      end
      mismatches++;
   endtask

   // predict on each accepted byte, check each accepted token
   always @(posedge clock) begin
      if (reset) begin
         reset_scan();
      end else begin
         if (req_valid && req_ready) begin
            scan_beat(req_kind, req_text_byte);
         end
         if (rsp_valid && rsp_ready) begin
            if (tokens_due.size() == 0) begin
               report_mismatch("token with nothing expected, type", rsp_token_type, 0);
            end else begin
               want = tokens_due.pop_front();
               if (rsp_token_type !== want.token_type)
                  report_mismatch("token_type", rsp_token_type, want.token_type);
               if (rsp_error_code !== want.error_code)
                  report_mismatch("error_code", rsp_error_code, want.error_code);
               if (rsp_start_line !== want.start_line)
                  report_mismatch("start_line", rsp_start_line, want.start_line);
               if (rsp_start_column !== want.start_column)
                  report_mismatch("start_column", rsp_start_column, want.start_column);
               if (rsp_start_offset !== want.start_offset)
                  report_mismatch("start_offset", rsp_start_offset, want.start_offset);
               if (rsp_token_length !== want.token_length)
                  report_mismatch("token_length", rsp_token_length, want.token_length);
               if (rsp_last_of_run !== want.last_of_run)
                  report_mismatch("last_of_run", rsp_last_of_run, want.last_of_run);
            end
            results_checked++;
         end
      end
   end

   // token side back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   // give up when nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // one beat on the byte channel, with random gaps in front
   task automatic send_beat(input logic kind, input logic [CHAR_BITS-1:0] c);
      while ($urandom_range(0, 99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_text_byte <= c;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      beats_sent++;
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) begin
         send_beat(KIND_BYTE, s[i]);
      end
   endtask

   // the byte field carries junk on an end beat
   task automatic send_end_of_text();
      send_beat(KIND_END, CHAR_BITS'($urandom_range(0, 255)));
   endtask

   // hold the byte channel until every predicted token has come out
   task wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tokens_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic logic [CHAR_BITS-1:0] random_word_char(input bit lead);
      int unsigned pick;
      logic [CHAR_BITS-1:0] c;
      pick = lead ? $urandom_range(0, 52) : $urandom_range(0, 62);
      if (pick < 26) begin
         c = "a";
         c = c + pick[7:0];
      end else if (pick < 52) begin
         c = "A";
         c = c + pick[7:0] - 8'd26;
      end else if (pick == 52) begin
         c = "_";
      end else begin
         c = "0";
         c = c + pick[7:0] - 8'd53;
      end
      return c;
   endfunction

   function automatic logic [CHAR_BITS-1:0] random_space();
      case ($urandom_range(0, 7))
         0: return CH_TAB;
         1: return CH_LF;
         2: return CH_VT;
         3: return CH_FF;
         4: return CH_CR;
         default: return CH_SPACE;
      endcase
   endfunction

   // every single-character token, bang then not-equal
   task test_punctuation();
      send_text("(){};~*/%^+-<>&|!!=");
      send_end_of_text();
   endtask

   // greedy pairs, a broken pair followed by punctuation, operator left at end
   task test_operator_pairs();
      send_text("++--<=<<");
      wait_drained();
      send_text(">=>>==&&||+(<");
      send_end_of_text();
   endtask

   // exact keywords, near misses, number cut short by a letter
   task test_words();
      send_text("int return void intx in retur 12ab _x9 y(");
      send_text("\tVoid\n7");
      send_end_of_text();
   endtask

   // lone equals, unexpected bytes, discarding, empty text
   task test_errors();
      send_text("a=b c");
      send_end_of_text();
      send_text("=");
      send_end_of_text();
      send_text("x@y");
      send_end_of_text();
      send_beat(KIND_BYTE, 8'hFF);
      send_end_of_text();
      send_beat(KIND_BYTE, 8'h00);
      send_text("q");
      send_end_of_text();
      send_text("!");
      send_end_of_text();
      send_end_of_text();
   endtask

   // lengths past the saturation point, keyword head on a long word
   task test_long_tokens();
      send_text("return");
      repeat (LONG_RUN - 6) send_beat(KIND_BYTE, random_word_char(1'b0));
      send_text(";");
      repeat (LONG_RUN) send_beat(KIND_BYTE, "0" + 8'($urandom_range(0, 9)));
      send_end_of_text();
   endtask

   // mostly well-formed texts, with some noise and early ends
   task automatic send_random_text();
      string       lone_ops = "(){};~+-*/%<>&|^!";
      string       pair_ops = "++--<=<<>=>>==&&||!=";
      int unsigned count;
      int unsigned pick;
      int unsigned len;
      int unsigned i;
      int unsigned j;
      count = $urandom_range(2, 14);
      for (i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 6);
            send_beat(KIND_BYTE, random_word_char(1'b1));
            for (j = 1; j < len; j++) begin
               send_beat(KIND_BYTE, random_word_char(1'b0));
            end
         end else if (pick < 32) begin
            case ($urandom_range(0, 9))
               0: send_text("int");
               1: send_text("return");
               2: send_text("void");
               3: send_text("in");
               4: send_text("intx");
               5: send_text("returns");
               6: send_text("voi");
               7: send_text("_int");
               8: send_text("Int");
               default: send_text("void_");
            endcase
         end else if (pick < 50) begin
            repeat ($urandom_range(1, 5)) send_beat(KIND_BYTE, "0" + 8'($urandom_range(0, 9)));
         end else if (pick < 68) begin
            send_beat(KIND_BYTE, lone_ops[$urandom_range(0, lone_ops.len() - 1)]);
         end else if (pick < 84) begin
            j = 2 * $urandom_range(0, 9);
            send_beat(KIND_BYTE, pair_ops[j]);
            send_beat(KIND_BYTE, pair_ops[j + 1]);
         end else if (pick < 94) begin
            repeat ($urandom_range(1, 4)) send_beat(KIND_BYTE, random_space());
         end else if (pick < 96) begin
            send_text("=");
         end else if (pick < 98) begin
            send_beat(KIND_BYTE, CHAR_BITS'($urandom_range(0, 255)));
         end else begin
            send_end_of_text();
         end
         if ($urandom_range(0, 1) == 1) begin
            send_beat(KIND_BYTE, random_space());
         end
         if ($urandom_range(0, 63) == 0) begin
            wait_drained();
         end
      end
      send_end_of_text();
   endtask

   task test_random_text(input int unsigned beats);
      int unsigned target;
      target = beats_sent + beats;
      while (beats_sent < target) begin
         send_random_text();
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // sender mostly busy, receiver mostly stalled
      sender_gap_pct     = 13;
      receiver_stall_pct = 87;
      test_punctuation();
      test_operator_pairs();
      test_words();
      test_errors();
      test_random_text(150);

      // sender mostly idle, receiver mostly ready
      sender_gap_pct     = 87;
      receiver_stall_pct = 13;
      test_long_tokens();
      test_random_text(150);

      // full rate on both sides
      sender_gap_pct     = 0;
      receiver_stall_pct = 0;
      test_random_text(150);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
